// ===== rtl/fsts_pkg.sv =====
package fsts_pkg;

    localparam int LIGHT_SHIFT = 20;
    localparam int LIGHT_BANDS = 128;
    localparam int BAND_W      = 7;
    localparam int DY_W        = 26;   // row distance in 16.16, always below 2^26
    localparam int QUOT_W      = 31;   // quotient bits produced by the divider
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_SINE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_COSINE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DETAIL      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LIGHT = 3'd7;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [17:0] view_sine;
        logic signed [17:0] view_cosine;
        logic [9:0]         center_column;
        logic [9:0]         center_row;
        logic               detail_shift;
        logic               fixed_light_mode;
    } cfg_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] first;
        logic [9:0] last;
    } span_t;

    typedef struct packed {
        span_t              span;
        logic signed [10:0] dx;
        logic [31:0]        cos_dist;
        logic [31:0]        sin_dist;
        logic [BAND_W-1:0]  band;
    } side_t;

    typedef struct packed {
        logic [DY_W-1:0]   rem;
        logic [QUOT_W-1:0] num;
        logic [QUOT_W-1:0] quo;
        logic              neg;
        logic              ovf;
    } lane_t;

    typedef struct packed {
        lane_t           lx;
        lane_t           ly;
        logic [DY_W-1:0] dy;
        side_t           side;
    } div_t;

endpackage

// ===== rtl/flat_span_texture_setup_unit.sv =====
// Floor and ceiling span texture setup.
//
// Input stream (s_): one span per item: row, first and last column, plane
// height above the eye and the row's distance slope. Output stream (m_): the
// span's columns passed through, 16.16 texture start and step for x and y,
// the distance light band and the fixed light flag. A span on the center row
// is dropped and gives no output item.
// View registers are loaded through the cfg_ write port, one per write;
// the user must do so only while no span is in flight; the block does not check.
// From input accept to output a span passes two registered setup stages
// (multipliers, then divider preparation), 31 divider stages that each
// resolve one quotient bit for both steps, and three finishing stages.
// Throughput is one span per cycle while m_tready does not stall the
// pipeline; the 31-stage restoring divider sets the depth. A stall on
// m_tready freezes the whole pipeline and drops s_tready in the same cycle,
// so nothing is lost or repeated; the output register frees the input side
// as soon as its item is taken.
// Reset clears all valid bits and loads the view registers with cosine
// 1.0, center column 160, center row 100 and all others zero.
module flat_span_texture_setup_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row[9:0], first_column[19:10], last_column[29:20], plane_height[60:30],
    // row_slope[91:61], zero fill[95:92]
    input  logic [95:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_row[9:0], out_first[19:10], out_last[29:20], tex_x_start[61:30],
    // tex_y_start[93:62], tex_x_step[125:94], tex_y_step[157:126],
    // light_band[164:158], fixed_light[165], zero fill[167:166]
    output logic [167:0]                     m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_wdata
);

    fsts_pkg::cfg_t cfg_reg;

    // view register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_x           <= '0;
            cfg_reg.view_y           <= '0;
            cfg_reg.view_sine        <= '0;
            cfg_reg.view_cosine      <= 18'sd65536;
            cfg_reg.center_column    <= 10'd160;
            cfg_reg.center_row       <= 10'd100;
            cfg_reg.detail_shift     <= 1'b0;
            cfg_reg.fixed_light_mode <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fsts_pkg::REG_VIEW_X:      cfg_reg.view_x           <= cfg_wdata;
                fsts_pkg::REG_VIEW_Y:      cfg_reg.view_y           <= cfg_wdata;
                fsts_pkg::REG_VIEW_SINE:   cfg_reg.view_sine        <= cfg_wdata[17:0];
                fsts_pkg::REG_VIEW_COSINE: cfg_reg.view_cosine      <= cfg_wdata[17:0];
                fsts_pkg::REG_CENTER_COL:  cfg_reg.center_column    <= cfg_wdata[9:0];
                fsts_pkg::REG_CENTER_ROW:  cfg_reg.center_row       <= cfg_wdata[9:0];
                fsts_pkg::REG_DETAIL:      cfg_reg.detail_shift     <= cfg_wdata[0];
                fsts_pkg::REG_FIXED_LIGHT: cfg_reg.fixed_light_mode <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // advance every stage together whenever the output register can move
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    fsts_pkg::div_t front_d;
    logic           front_v;
    fsts_pkg::div_t div_d;
    logic           div_v;

    fsts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (s_tvalid),
        .row         (s_tdata[9:0]),
        .first_column(s_tdata[19:10]),
        .last_column (s_tdata[29:20]),
        .plane_height(s_tdata[60:30]),
        .row_slope   (s_tdata[91:61]),
        .cfg         (cfg_reg),
        .div_out     (front_d),
        .div_valid   (front_v)
    );

    fsts_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (front_v),
        .d_in     (front_d),
        .out_valid(div_v),
        .d_out    (div_d)
    );

    fsts_pkg::span_t             out_span;
    logic [31:0]                 tex_x_start;
    logic [31:0]                 tex_y_start;
    logic [31:0]                 tex_x_step;
    logic [31:0]                 tex_y_step;
    logic [fsts_pkg::BAND_W-1:0] light_band;
    logic                        fixed_light;

    fsts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (div_v),
        .d_in       (div_d),
        .cfg        (cfg_reg),
        .out_valid  (m_tvalid),
        .out_span   (out_span),
        .tex_x_start(tex_x_start),
        .tex_y_start(tex_y_start),
        .tex_x_step (tex_x_step),
        .tex_y_step (tex_y_step),
        .light_band (light_band),
        .fixed_light(fixed_light)
    );

    assign m_tdata = {2'b0, fixed_light, light_band, tex_y_step, tex_x_step,
                      tex_y_start, tex_x_start, out_span.last, out_span.first,
                      out_span.row};

endmodule

// ===== rtl/fsts_front.sv =====
module fsts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [9:0]        row,
    input  logic [9:0]        first_column,
    input  logic [9:0]        last_column,
    input  logic [30:0]       plane_height,
    input  logic [30:0]       row_slope,
    input  fsts_pkg::cfg_t    cfg,
    output fsts_pkg::div_t    div_out,
    output logic              div_valid
);

    // stage A: row distance and the three height products
    logic                             below;
    logic [9:0]                       d;
    logic [fsts_pkg::DY_W-1:0]        dy_a;
    logic [61:0]                      dist_prod;
    logic signed [49:0]               ax_prod;
    logic signed [49:0]               ay_prod;
    logic signed [10:0]               dx_a;

    logic                             a_valid_reg;
    fsts_pkg::span_t                  a_span_reg;
    logic signed [10:0]               a_dx_reg;
    logic [fsts_pkg::DY_W-1:0]        a_dy_reg;
    logic [31:0]                      a_dist_reg;
    logic [31:0]                      a_ax_reg;
    logic [31:0]                      a_ay_reg;

    assign below     = row < cfg.center_row;
    assign d         = below ? (cfg.center_row - row) : (row - cfg.center_row);
    assign dy_a      = below ? ({d, 16'b0} - 26'd32768) : ({d, 16'b0} + 26'd32768);
    assign dist_prod = plane_height * row_slope;
    assign ax_prod   = cfg.view_sine * $signed({1'b0, plane_height});
    assign ay_prod   = cfg.view_cosine * $signed({1'b0, plane_height});
    assign dx_a      = $signed({1'b0, first_column}) - $signed({1'b0, cfg.center_column});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= in_valid && (row != cfg.center_row);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_span_reg <= '{row: row, first: first_column, last: last_column};
            a_dx_reg   <= dx_a;
            a_dy_reg   <= dy_a;
            a_dist_reg <= dist_prod[47:16];
            a_ax_reg   <= ax_prod[47:16];
            a_ay_reg   <= ay_prod[47:16];
        end
    end

    // stage B: view products on distance, light band, divider setup
    logic signed [49:0]               cos_prod;
    logic signed [49:0]               sin_prod;
    logic [31:0]                      ax_abs;
    logic [31:0]                      ay_abs;
    logic [31-fsts_pkg::LIGHT_SHIFT:0] dist_hi;
    logic [fsts_pkg::BAND_W-1:0]      band;
    fsts_pkg::div_t                   div_next;
    fsts_pkg::div_t                   div_reg;
    logic                             b_valid_reg;

    assign cos_prod = cfg.view_cosine * $signed(a_dist_reg);
    assign sin_prod = cfg.view_sine * $signed(a_dist_reg);
    assign ax_abs   = a_ax_reg[31] ? (32'd0 - a_ax_reg) : a_ax_reg;
    assign ay_abs   = a_ay_reg[31] ? (32'd0 - a_ay_reg) : a_ay_reg;
    assign dist_hi  = a_dist_reg[31:fsts_pkg::LIGHT_SHIFT];

    always_comb begin
        if (a_dist_reg[31] || (dist_hi >= fsts_pkg::LIGHT_BANDS)) begin
            band = fsts_pkg::BAND_W'(fsts_pkg::LIGHT_BANDS - 1);
        end else begin
            band = dist_hi[fsts_pkg::BAND_W-1:0];
        end
    end

    always_comb begin
        div_next.lx.rem  = {9'b0, ax_abs[31:15]};
        div_next.lx.num  = {ax_abs[14:0], 16'b0};
        div_next.lx.quo  = '0;
        div_next.lx.neg  = a_ax_reg[31];
        div_next.lx.ovf  = {8'b0, ax_abs[31:14]} >= a_dy_reg;
        div_next.ly.rem  = {9'b0, ay_abs[31:15]};
        div_next.ly.num  = {ay_abs[14:0], 16'b0};
        div_next.ly.quo  = '0;
        div_next.ly.neg  = a_ay_reg[31];
        div_next.ly.ovf  = {8'b0, ay_abs[31:14]} >= a_dy_reg;
        div_next.dy      = a_dy_reg;
        div_next.side.span     = a_span_reg;
        div_next.side.dx       = a_dx_reg;
        div_next.side.cos_dist = cos_prod[47:16];
        div_next.side.sin_dist = sin_prod[47:16];
        div_next.side.band     = band;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            div_reg <= div_next;
        end
    end

    assign div_out   = div_reg;
    assign div_valid = b_valid_reg;

endmodule

// ===== rtl/fsts_div_step.sv =====
module fsts_div_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  fsts_pkg::div_t d_in,
    output logic           out_valid,
    output fsts_pkg::div_t d_out
);

    function automatic fsts_pkg::lane_t lane_step(input fsts_pkg::lane_t l,
                                                  input logic [fsts_pkg::DY_W-1:0] dy);
        logic [fsts_pkg::DY_W:0] r_sh;
        logic                    take;
        fsts_pkg::lane_t         o;
        r_sh  = {l.rem, l.num[fsts_pkg::QUOT_W-1]};
        take  = r_sh >= {1'b0, dy};
        o     = l;
        o.rem = take ? fsts_pkg::DY_W'(r_sh - {1'b0, dy}) : r_sh[fsts_pkg::DY_W-1:0];
        o.num = {l.num[fsts_pkg::QUOT_W-2:0], 1'b0};
        o.quo = {l.quo[fsts_pkg::QUOT_W-2:0], take};
        return o;
    endfunction

    fsts_pkg::div_t d_next;
    fsts_pkg::div_t d_reg;
    logic           valid_reg;

    always_comb begin
        d_next    = d_in;
        d_next.lx = lane_step(d_in.lx, d_in.dy);
        d_next.ly = lane_step(d_in.ly, d_in.dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

    assign d_out     = d_reg;
    assign out_valid = valid_reg;

endmodule

// ===== rtl/fsts_divider.sv =====
module fsts_divider (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  fsts_pkg::div_t d_in,
    output logic           out_valid,
    output fsts_pkg::div_t d_out
);

    fsts_pkg::div_t d_chain [fsts_pkg::QUOT_W+1];
    logic           v_chain [fsts_pkg::QUOT_W+1];

    assign d_chain[0] = d_in;
    assign v_chain[0] = in_valid;

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < fsts_pkg::QUOT_W; i++) begin : g_step
        fsts_div_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .in_valid (v_chain[i]),
            .d_in     (d_chain[i]),
            .out_valid(v_chain[i+1]),
            .d_out    (d_chain[i+1])
        );
    end

    assign d_out     = d_chain[fsts_pkg::QUOT_W];
    assign out_valid = v_chain[fsts_pkg::QUOT_W];

endmodule

// ===== rtl/fsts_back.sv =====
module fsts_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  fsts_pkg::div_t              d_in,
    input  fsts_pkg::cfg_t              cfg,
    output logic                        out_valid,
    output fsts_pkg::span_t             out_span,
    output logic [31:0]                 tex_x_start,
    output logic [31:0]                 tex_y_start,
    output logic [31:0]                 tex_x_step,
    output logic [31:0]                 tex_y_step,
    output logic [fsts_pkg::BAND_W-1:0] light_band,
    output logic                        fixed_light
);

    // stage C: sign, saturate and scale the quotients
    logic [31:0]     qx;
    logic [31:0]     qy;
    logic            c_valid_reg;
    logic [31:0]     c_stepx_reg;
    logic [31:0]     c_stepy_reg;
    fsts_pkg::side_t c_side_reg;

    always_comb begin
        if (d_in.lx.ovf) begin
            qx = d_in.lx.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            qx = d_in.lx.neg ? (32'd0 - {1'b0, d_in.lx.quo}) : {1'b0, d_in.lx.quo};
        end
        if (d_in.ly.ovf) begin
            qy = d_in.ly.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            qy = d_in.ly.neg ? (32'd0 - {1'b0, d_in.ly.quo}) : {1'b0, d_in.ly.quo};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_stepx_reg <= cfg.detail_shift ? {qx[30:0], 1'b0} : qx;
            c_stepy_reg <= cfg.detail_shift ? {qy[30:0], 1'b0} : qy;
            c_side_reg  <= d_in.side;
        end
    end

    // stage D: column offset times step
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               d_valid_reg;
    logic [31:0]        d_px_reg;
    logic [31:0]        d_py_reg;
    logic [31:0]        d_stepx_reg;
    logic [31:0]        d_stepy_reg;
    fsts_pkg::side_t    d_side_reg;

    assign px = c_side_reg.dx * $signed(c_stepx_reg);
    assign py = c_side_reg.dx * $signed(c_stepy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_px_reg    <= px;
            d_py_reg    <= py;
            d_stepx_reg <= c_stepx_reg;
            d_stepy_reg <= c_stepy_reg;
            d_side_reg  <= c_side_reg;
        end
    end

    // stage E: start coordinates into the output register
    logic                        e_valid_reg;
    fsts_pkg::span_t             e_span_reg;
    logic [31:0]                 e_xs_reg;
    logic [31:0]                 e_ys_reg;
    logic [31:0]                 e_stepx_reg;
    logic [31:0]                 e_stepy_reg;
    logic [fsts_pkg::BAND_W-1:0] e_band_reg;
    logic                        e_fixed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (ce) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_span_reg  <= d_side_reg.span;
            e_xs_reg    <= cfg.view_x + d_side_reg.cos_dist + d_px_reg;
            e_ys_reg    <= 32'd0 - cfg.view_y - d_side_reg.sin_dist + d_py_reg;
            e_stepx_reg <= d_stepx_reg;
            e_stepy_reg <= d_stepy_reg;
            e_band_reg  <= cfg.fixed_light_mode ? '0 : d_side_reg.band;
            e_fixed_reg <= cfg.fixed_light_mode;
        end
    end

    assign out_valid   = e_valid_reg;
    assign out_span    = e_span_reg;
    assign tex_x_start = e_xs_reg;
    assign tex_y_start = e_ys_reg;
    assign tex_x_step  = e_stepx_reg;
    assign tex_y_step  = e_stepy_reg;
    assign light_band  = e_band_reg;
    assign fixed_light = e_fixed_reg;

endmodule

// ===== tb/sv/tb.sv =====
module tb;

    // Block latency from input accept to output valid, plus margin.
    localparam int LATENCY = 36;
    localparam int N_RANDOM = 850;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // row, first_column, last_column, plane_height, row_slope, zero fill
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // out_row, out_first, out_last, tex_x_start, tex_y_start, tex_x_step,
    // tex_y_step, light_band, fixed_light, zero fill
    logic [167:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [fsts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    flat_span_texture_setup_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    typedef struct {
        logic [9:0] row, first, last;
        logic [30:0] height, slope;
    } span_in_t;

    // Shadow copy of the view registers.
    fsts_pkg::cfg_t view;

    logic [167:0] span_results_q[$];
    int mismatches = 0;
    int n_results = 0;
    int n_dropped = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic logic signed [31:0] fx_mul(longint a, longint b);
        longint p;
        p = (a * b) >>> 16;
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] fx_div(longint a, longint b);
        longint aa, ab, q;
        aa = a < 0 ? -a : a;
        ab = b < 0 ? -b : b;
        if ((aa >>> 14) >= ab || b == 0)
            return ((a < 0) != (b < 0)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q = (a * 65536) / b;
        return q[31:0];
    endfunction

    // Compute the texture setup for one span; returns 0 on the center row.
    function automatic bit span_setup(span_in_t sp, output logic [167:0] res);
        longint d, dy, dist_l, dx;
        logic signed [31:0] distance, xstep, ystep, xs, ys, t;
        logic [6:0] band;
        res = '0;
        if (sp.row == view.center_row) return 0;
        d = sp.row < view.center_row ? longint'(view.center_row) - sp.row
                                     : longint'(sp.row) - view.center_row;
        dy = d * 65536 + (sp.row < view.center_row ? -32768 : 32768);
        distance = fx_mul(longint'(sp.height), longint'(sp.slope));
        dist_l = distance;
        xstep = fx_div(fx_mul(view.view_sine, sp.height), dy) << view.detail_shift;
        ystep = fx_div(fx_mul(view.view_cosine, sp.height), dy) << view.detail_shift;
        dx = longint'(sp.first) - longint'(view.center_column);
        t = 32'(dx * longint'(xstep));
        xs = view.view_x + fx_mul(view.view_cosine, dist_l) + t;
        t = 32'(dx * longint'(ystep));
        ys = -view.view_y - fx_mul(view.view_sine, dist_l) + t;
        band = '0;
        if (!view.fixed_light_mode) begin
            if (distance < 0 ||
                (distance >>> fsts_pkg::LIGHT_SHIFT) >= fsts_pkg::LIGHT_BANDS)
                band = 7'(fsts_pkg::LIGHT_BANDS - 1);
            else
                band = 7'(distance >>> fsts_pkg::LIGHT_SHIFT);
        end
        res = {2'b00, view.fixed_light_mode, band, ystep, xstep, ys, xs,
               sp.last, sp.first, sp.row};
        return 1;
    endfunction

    task automatic write_reg(logic [fsts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fsts_pkg::REG_VIEW_X:      view.view_x = val;
            fsts_pkg::REG_VIEW_Y:      view.view_y = val;
            fsts_pkg::REG_VIEW_SINE:   view.view_sine = val[17:0];
            fsts_pkg::REG_VIEW_COSINE: view.view_cosine = val[17:0];
            fsts_pkg::REG_CENTER_COL:  view.center_column = val[9:0];
            fsts_pkg::REG_CENTER_ROW:  view.center_row = val[9:0];
            fsts_pkg::REG_DETAIL:      view.detail_shift = val[0];
            fsts_pkg::REG_FIXED_LIGHT: view.fixed_light_mode = val[0];
            default: begin
            end
        endcase
    endtask

    // Drop the input, then wait for the pipeline to empty; dropped spans may
    // still be in flight.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (span_results_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Offer one span and hold it until accepted; use_exp forces a typed result.
    task automatic send_span(span_in_t sp, bit use_exp, logic [167:0] typed);
        logic [167:0] res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        if (span_setup(sp, res)) begin
            span_results_q.push_back(use_exp ? typed : res);
        end else begin
            n_dropped++;
        end
        s_tdata <= {4'b0, sp.slope, sp.height, sp.last, sp.first, sp.row};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: random stalls, compare against the oldest expectation.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (span_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_tdata);
            end else begin
                logic [167:0] want;
                want = span_results_q.pop_front();
                if (want !== m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h (xor %h)",
                                 want, m_tdata, want ^ m_tdata);
                end
            end
        end
    end

    function automatic span_in_t rand_span(bit wellformed);
        span_in_t sp;
        sp.row = 10'($urandom);
        sp.first = 10'($urandom);
        sp.last = 10'($urandom);
        sp.height = 31'($urandom);
        sp.slope = 31'($urandom);
        if (wellformed) begin
            // Realistic spans: ordered columns, mostly modest height and slope, one row in ten on center.
            if (sp.first > sp.last) {sp.first, sp.last} = {sp.last, sp.first};
            case ($urandom_range(3))
                0: sp.height = 31'($urandom_range(32'h0FFF_FFFF));
                1: sp.height = 31'($urandom_range(32'h00FF_FFFF));
                default: sp.height = 31'($urandom);
            endcase
            sp.slope = $urandom_range(3) == 0 ? sp.slope
                                              : 31'($urandom_range(32'h00FF_FFFF));
            if ($urandom_range(9) == 0) sp.row = view.center_row;
        end
        return sp;
    endfunction

    typedef struct {
        span_in_t sp;
        bit typed;
        logic [167:0] res;
    } dir_row_t;

    initial begin : timeout
        #4000000;
        $display("flat_span_texture_setup_unit verification failed");
        $finish;
    end

    initial begin : main
        dir_row_t dir[$];
        dir_row_t r;
        logic [31:0] setting;
        view = '{view_x: 0, view_y: 0, view_sine: 0, view_cosine: 18'sd65536,
                 center_column: 10'd160, center_row: 10'd100,
                 detail_shift: 1'b0, fixed_light_mode: 1'b0};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows, reset view. Zero height gives all-zero texture values.
        r.sp = '{10'd101, 10'd160, 10'd170, 31'd0, 31'd0}; r.typed = 1;
        r.res = {2'b0, 1'b0, 7'd0, 128'd0, 10'd170, 10'd160, 10'd101};
        dir.push_back(r);
        // Center row: dropped.
        r.sp = '{10'd100, 10'd0, 10'd1023, 31'h7FFF_FFFF, 31'h7FFF_FFFF}; r.typed = 0;
        dir.push_back(r);
        r.sp = '{10'd0, 10'd0, 10'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF}; dir.push_back(r);
        r.sp = '{10'd1023, 10'd1023, 10'd0, 31'h7FFF_FFFF, 31'd1}; dir.push_back(r);
        r.sp = '{10'd99, 10'd1023, 10'd1023, 31'h0001_0000, 31'h0100_0000}; dir.push_back(r);
        r.sp = '{10'd101, 10'd0, 10'd5, 31'h4000_0000, 31'h0001_0000}; dir.push_back(r);
        r.sp = '{10'd50, 10'd10, 10'd300, 31'h0080_0000, 31'h0004_0000}; dir.push_back(r);
        r.sp = '{10'd200, 10'd319, 10'd100, 31'h0020_0000, 31'h7FFF_FFFF}; dir.push_back(r);
        foreach (dir[i]) send_span(dir[i].sp, dir[i].typed, dir[i].res);
        drain();

        // Extreme view settings: every register, then new sine, cosine, center and fixed light values.
        write_reg(fsts_pkg::REG_VIEW_X, 32'h7FFF_FFFF);
        write_reg(fsts_pkg::REG_VIEW_Y, 32'h8000_0000);
        write_reg(fsts_pkg::REG_VIEW_SINE, 32'h0001_0000);
        write_reg(fsts_pkg::REG_VIEW_COSINE, 32'hFFFF_0000);
        write_reg(fsts_pkg::REG_CENTER_COL, 32'd1023);
        write_reg(fsts_pkg::REG_CENTER_ROW, 32'd0);
        write_reg(fsts_pkg::REG_DETAIL, 32'd1);
        write_reg(fsts_pkg::REG_FIXED_LIGHT, 32'd1);
        foreach (dir[i]) send_span(dir[i].sp, 0, '0);
        drain();
        write_reg(fsts_pkg::REG_VIEW_SINE, 32'hFFFF_0000);
        write_reg(fsts_pkg::REG_VIEW_COSINE, 32'h0000_0000);
        write_reg(fsts_pkg::REG_CENTER_ROW, 32'd1023);
        write_reg(fsts_pkg::REG_CENTER_COL, 32'd0);
        write_reg(fsts_pkg::REG_FIXED_LIGHT, 32'd0);
        foreach (dir[i]) send_span(dir[i].sp, 0, '0);
        drain();

        // Random phases: idle profiles rotate, view settings change between.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph % 3 == 0) ? 25 : (ph % 3 == 1) ? 76 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 76 : (ph % 3 == 1) ? 25 : 0;
            for (int i = 0; i < N_RANDOM / 6; i++)
                send_span(rand_span($urandom_range(9) != 0), 0, '0);
            drain();
            for (int k = 0; k < 8; k++) begin
                setting = $urandom;
                if (k == 2 || k == 3)
                    setting = 32'($signed($urandom_range(131072)) - 65536);
                else if (k == 4 || k == 5)
                    setting = $urandom_range(99) < 20 ? (k == 4 ? 32'd1023 : 32'd0)
                                                      : $urandom_range(1023);
                write_reg(fsts_pkg::CFG_IDX_W'(k), setting);
            end
        end
        recv_idle_pct = 0;
        drain();

        $display("spans checked: %0d results, %0d center-row drops, %0d mismatches",
                 n_results, n_dropped, mismatches);
        if (mismatches == 0 && span_results_q.size() == 0)
            $display("flat_span_texture_setup_unit verification clean");
        else
            $display("flat_span_texture_setup_unit verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/fsts_pkg.sv
rtl/fsts_front.sv
rtl/fsts_div_step.sv
rtl/fsts_divider.sv
rtl/fsts_back.sv
rtl/flat_span_texture_setup_unit.sv
tb/sv/tb.sv
